/* rtl/rpw_pkg.sv */
// Shared types and codes for the resource pool with FIFO waiters.
// Used by the controller, the datapath, the top level and the checker.
package rpw_pkg;

	localparam int ID_W   = 4;
	localparam int TAG_W  = 8;
	localparam int CNT_W  = 5;
	localparam int ACT_W  = 2;
	localparam int STS_W  = 4;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// action codes carried by an input word; the fourth code is ignored
	localparam logic [ACT_W-1:0] ACT_ACQUIRE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLOSE   = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_POOL_COUNT = 1'b0;

	localparam logic [CNT_W-1:0] POOL_COUNT_RST = 5'd16;

	typedef enum logic [STS_W-1:0] {
		STS_GRANTED        = 4'd0,
		STS_QUEUED         = 4'd1,
		STS_REFUSED_CLOSED = 4'd2,
		STS_REFUSED_FULL   = 4'd3,
		STS_HANDED         = 4'd4,
		STS_RETURNED       = 4'd5,
		STS_CANCELLED      = 4'd6,
		STS_CLOSE_DONE     = 4'd7,
		STS_ALREADY_CLOSED = 4'd8,
		STS_OVERFLOW       = 4'd9
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DRAIN,
		ST_GAP,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LATCH,
		OP_EXEC,
		OP_CANCEL,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             closed;
		logic             no_waiters;
		logic             one_waiter;
		logic             out_free;
	} dp_status_t;

endpackage

/* rtl/rpw_ctrl.sv */
// Controller state machine for the resource pool.
// Depends on rpw_pkg; drives command words into rpw_dp.
module rpw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  rpw_pkg::dp_status_t sts,
	output logic                req_stall,
	output rpw_pkg::dp_cmd_t    cmd
);
	import rpw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.op  = OP_LATCH;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.out_free) begin
					cmd.op = OP_EXEC;
					// an open pool with waiters goes on to cancel them
					if (sts.action == ACT_CLOSE && !sts.closed && !sts.no_waiters) begin
						state_d = ST_DRAIN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DRAIN: begin
				if (sts.out_free) begin
					cmd.op  = OP_CANCEL;
					state_d = sts.one_waiter ? ST_FINISH : ST_GAP;
				end
			end
			ST_GAP: begin
				// let the queue read catch up with the new head
				state_d = ST_DRAIN;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.op  = OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/rpw_dp.sv */
// Datapath of the resource pool: free stack, waiter queue, counters, output register.
// Depends on rpw_pkg; commanded by rpw_ctrl.
module rpw_dp #(
	parameter int POOL_SLOTS   = 16,
	parameter int WAITER_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rpw_pkg::dp_cmd_t                  cmd,
	output rpw_pkg::dp_status_t               sts,
	input  logic                              cfg_we,
	input  logic [rpw_pkg::CNT_W-1:0]         cfg_count,
	input  logic [rpw_pkg::ACT_W-1:0]         action,
	input  logic [rpw_pkg::TAG_W-1:0]         requester_tag,
	input  logic [rpw_pkg::ID_W-1:0]          context_id,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [rpw_pkg::STS_W-1:0]         status,
	output logic [rpw_pkg::TAG_W-1:0]         requester_tag_res,
	output logic [rpw_pkg::ID_W-1:0]          context_id_res,
	output logic [rpw_pkg::CNT_W-1:0]         free_count,
	output logic [rpw_pkg::CNT_W-1:0]         waiter_count,
	output logic                              last
);
	import rpw_pkg::*;

	localparam int DW     = $clog2(POOL_SLOTS + 1);
	localparam int SAW    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int TW     = $clog2(WAITER_DEPTH + 1);
	localparam int WAW    = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
	localparam int RST_N  = (int'(POOL_COUNT_RST) > POOL_SLOTS) ? POOL_SLOTS
	                                                             : int'(POOL_COUNT_RST);

	// free stack and waiter queue
	logic [ID_W-1:0]  stack_mem [POOL_SLOTS];
	logic [TAG_W-1:0] fifo_mem [WAITER_DEPTH];
	logic [ID_W-1:0]  stack_rd_q;
	logic [TAG_W-1:0] fifo_rd_q;

	logic [DW-1:0]    depth_q, depth_d;
	logic [DW-1:0]    orig_q, orig_d;
	logic [WAW-1:0]   head_q, head_d, head_nx;
	logic [WAW-1:0]   tail_q, tail_d, tail_nx;
	logic [TW-1:0]    total_q, total_d;
	logic             closed_q, closed_d;

	logic [ACT_W-1:0] act_q;
	logic [TAG_W-1:0] tag_q;
	logic [ID_W-1:0]  id_q;

	logic             rsp_valid_q;
	logic [STS_W-1:0] rsp_status_q;
	logic [TAG_W-1:0] rsp_tag_q;
	logic [ID_W-1:0]  rsp_id_q;
	logic [CNT_W-1:0] rsp_free_q;
	logic [CNT_W-1:0] rsp_wait_q;
	logic             rsp_last_q;

	logic             out_free;
	logic [DW-1:0]    top_idx;
	logic [DW+ID_W-1:0] top_ext;
	logic [ID_W-1:0]  top_id;
	logic             stack_full, fifo_full, no_waiters, one_waiter;
	logic [DW+CNT_W-1:0] cfg_ext;
	logic [DW+CNT_W-1:0] slots_ext;
	logic [DW-1:0]    install_n;

	logic             emit, e_last, wait_zero, stack_we, fifo_we;
	status_t          e_sts;
	logic [TAG_W-1:0] e_tag;
	logic [ID_W-1:0]  e_id;
	logic [DW+CNT_W-1:0] free_ext;
	logic [TW+CNT_W-1:0] wait_ext;

	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign top_idx    = depth_q - DW'(1);
	assign top_ext    = {{ID_W{1'b0}}, top_idx};
	// entries below the installed mark still hold their own index
	assign top_id     = (top_idx < orig_q) ? top_ext[ID_W-1:0] : stack_rd_q;
	assign stack_full = (depth_q == DW'(POOL_SLOTS));
	assign fifo_full  = (total_q == TW'(WAITER_DEPTH));
	assign no_waiters = (total_q == '0);
	assign one_waiter = (total_q == TW'(1));
	assign head_nx    = (head_q == WAW'(WAITER_DEPTH - 1)) ? '0 : head_q + WAW'(1);
	assign tail_nx    = (tail_q == WAW'(WAITER_DEPTH - 1)) ? '0 : tail_q + WAW'(1);

	// saturate the written count to the stack size
	assign cfg_ext    = {{DW{1'b0}}, cfg_count};
	assign slots_ext  = (DW+CNT_W)'(POOL_SLOTS);
	assign install_n  = (cfg_ext > slots_ext) ? slots_ext[DW-1:0] : cfg_ext[DW-1:0];

	assign sts.action     = act_q;
	assign sts.closed     = closed_q;
	assign sts.no_waiters = no_waiters;
	assign sts.one_waiter = one_waiter;
	assign sts.out_free   = out_free;

	always_comb begin
		emit      = 1'b0;
		e_last    = 1'b1;
		wait_zero = 1'b0;
		e_sts     = STS_GRANTED;
		e_tag     = '0;
		e_id      = '0;
		stack_we  = 1'b0;
		fifo_we   = 1'b0;
		depth_d   = depth_q;
		orig_d    = orig_q;
		head_d    = head_q;
		tail_d    = tail_q;
		total_d   = total_q;
		closed_d  = closed_q;
		case (cmd.op)
			OP_EXEC: begin
				case (act_q)
					ACT_ACQUIRE: begin
						emit  = 1'b1;
						e_tag = tag_q;
						if (closed_q) begin
							e_sts = STS_REFUSED_CLOSED;
						end else if (depth_q != '0) begin
							e_sts   = STS_GRANTED;
							e_id    = top_id;
							depth_d = depth_q - DW'(1);
						end else if (!fifo_full) begin
							e_sts   = STS_QUEUED;
							fifo_we = 1'b1;
							tail_d  = tail_nx;
							total_d = total_q + TW'(1);
						end else begin
							e_sts = STS_REFUSED_FULL;
						end
					end
					ACT_RELEASE: begin
						emit = 1'b1;
						e_id = id_q;
						if (!no_waiters) begin
							e_sts   = STS_HANDED;
							e_tag   = fifo_rd_q;
							head_d  = head_nx;
							total_d = total_q - TW'(1);
						end else if (!stack_full) begin
							e_sts    = STS_RETURNED;
							stack_we = 1'b1;
							depth_d  = depth_q + DW'(1);
							if (depth_q < orig_q) begin
								orig_d = depth_q;
							end
						end else begin
							e_sts = STS_OVERFLOW;
						end
					end
					ACT_CLOSE: begin
						if (closed_q) begin
							emit  = 1'b1;
							e_sts = STS_ALREADY_CLOSED;
						end else begin
							closed_d = 1'b1;
							if (no_waiters) begin
								emit   = 1'b1;
								e_sts  = STS_CLOSE_DONE;
								head_d = '0;
								tail_d = '0;
							end
						end
					end
					default: begin
					end
				endcase
			end
			OP_CANCEL: begin
				emit      = 1'b1;
				e_last    = 1'b0;
				wait_zero = 1'b1;
				e_sts     = STS_CANCELLED;
				e_tag     = fifo_rd_q;
				head_d    = head_nx;
				total_d   = total_q - TW'(1);
			end
			OP_FINISH: begin
				emit   = 1'b1;
				e_sts  = STS_CLOSE_DONE;
				head_d = '0;
				tail_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign free_ext = {{CNT_W{1'b0}}, depth_d};
	assign wait_ext = {{CNT_W{1'b0}}, total_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= DW'(RST_N);
			orig_q   <= DW'(RST_N);
			head_q   <= '0;
			tail_q   <= '0;
			total_q  <= '0;
			closed_q <= 1'b0;
		end else if (cfg_we) begin
			depth_q  <= install_n;
			orig_q   <= install_n;
		end else begin
			depth_q  <= depth_d;
			orig_q   <= orig_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			total_q  <= total_d;
			closed_q <= closed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[depth_q[SAW-1:0]] <= id_q;
		end
		stack_rd_q <= stack_mem[top_idx[SAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fifo_we) begin
			fifo_mem[tail_q] <= tag_q;
		end
		fifo_rd_q <= fifo_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			act_q <= action;
			tag_q <= requester_tag;
			id_q  <= context_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_status_q <= e_sts;
			rsp_tag_q    <= e_tag;
			rsp_id_q     <= e_id;
			rsp_free_q   <= free_ext[CNT_W-1:0];
			rsp_wait_q   <= wait_zero ? '0 : wait_ext[CNT_W-1:0];
			rsp_last_q   <= e_last;
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign status            = rsp_status_q;
	assign requester_tag_res = rsp_tag_q;
	assign context_id_res    = rsp_id_q;
	assign free_count        = rsp_free_q;
	assign waiter_count      = rsp_wait_q;
	assign last              = rsp_last_q;

endmodule

/* rtl/resource_pool_with_fifo_waiters_core.sv */
// Top level of the resource pool with FIFO waiters: register port and instances.
// Depends on rpw_pkg, rpw_ctrl and rpw_dp.
//
// Use:
//   Request channel (req_valid / req_stall): one word carries action, requester_tag
//   and context_id. A word is taken at a rising edge with req_valid high and
//   req_stall low. Acquire hands out the top free id or queues the tag; release
//   passes the id to the oldest waiter or pushes it back; close cancels every
//   waiter, oldest first, and ends with a close-done word.
//   Response channel (rsp_valid / rsp_stall): one word per result, last marks
//   the final word of a request. Action code 3 produces no word.
//   Timing: a request is latched in the idle state and executed in the exec
//   state once the output register is free; its result is registered there and
//   the controller returns to idle to take the next request. A close with
//   waiters emits one cancel per drain state, with a gap state between cancels
//   for the registered read of the waiter queue at its new head.
//   A stalled response holds its word; the request side may still take one
//   new word, which then waits for the output register to free up.
//   Reset: pool_count returns to 16, the stack holds ids 0 to 15 (highest on
//   top), the queue is empty and the pool is open. No clearing pass is needed.
//   Writing pool_count (address 0) rebuilds the stack at once; waiters and the
//   closed flag are kept. Write it only while the block is idle.
module resource_pool_with_fifo_waiters_core #(
	parameter int POOL_SLOTS   = 16,
	parameter int WAITER_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rpw_pkg::ADDR_W-1:0]    paddr,
	input  logic [rpw_pkg::DATA_W-1:0]    pwdata,
	output logic [rpw_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [rpw_pkg::ACT_W-1:0]     action,
	input  logic [rpw_pkg::TAG_W-1:0]     requester_tag,
	input  logic [rpw_pkg::ID_W-1:0]      context_id,
	// response channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [rpw_pkg::STS_W-1:0]     status,
	output logic [rpw_pkg::TAG_W-1:0]     requester_tag_res,
	output logic [rpw_pkg::ID_W-1:0]      context_id_res,
	output logic [rpw_pkg::CNT_W-1:0]     free_count,
	output logic [rpw_pkg::CNT_W-1:0]     waiter_count,
	output logic                          last
);
	import rpw_pkg::*;

	logic             cfg_we;
	logic [CNT_W-1:0] pool_count_q;
	dp_cmd_t          cmd;
	dp_status_t       sts;

	// no wait states on the register port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_COUNT);

	// hold the raw written count for read-back; the datapath saturates it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_count_q <= POOL_COUNT_RST;
		end else if (cfg_we) begin
			pool_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_POOL_COUNT) ? {{(DATA_W-CNT_W){1'b0}}, pool_count_q}
	                                             : '0;

	rpw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	rpw_dp #(
		.POOL_SLOTS   (POOL_SLOTS),
		.WAITER_DEPTH (WAITER_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_we),
		.cfg_count         (pwdata[CNT_W-1:0]),
		.action            (action),
		.requester_tag     (requester_tag),
		.context_id        (context_id),
		.rsp_valid         (rsp_valid),
		.rsp_stall         (rsp_stall),
		.status            (status),
		.requester_tag_res (requester_tag_res),
		.context_id_res    (context_id_res),
		.free_count        (free_count),
		.waiter_count      (waiter_count),
		.last              (last)
	);

endmodule

/* rtl/rpw_checker.sv */
// Port-level checker for the resource pool, bound to the top level.
// Depends on rpw_pkg.
module rpw_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_stall,
	input logic                      rsp_valid,
	input logic                      rsp_stall,
	input logic [rpw_pkg::STS_W-1:0] status,
	input logic [rpw_pkg::CNT_W-1:0] waiter_count,
	input logic                      last
);
	import rpw_pkg::*;

	// a cancel word is never the last of its close and reports a waiter count of zero
	a_cancel_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STS_CANCELLED |-> !last && waiter_count == '0)
		else $error("cancel word with last set or waiters left");

	// every other result ends its request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STS_CANCELLED |-> last)
		else $error("non-cancel word without last");

	// one request at a time: busy right after a word is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request side not busy after taking a word");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status))
		else $error("stalled response word changed");

endmodule

bind resource_pool_with_fifo_waiters_core rpw_checker u_rpw_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the resource pool with FIFO waiters.
// Depends on rpw_pkg and resource_pool_with_fifo_waiters_core; needs nothing else.
module tb_top;
	import rpw_pkg::*;

	// the fourth action code, which the block drops without a word
	localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
	localparam logic [ADDR_W-1:0] POOL_COUNT_ADDR = {REG_POOL_COUNT, 2'b00};
	localparam int SLOTS       = 16;
	localparam int QUEUE_DEPTH = 16;
	localparam int IDLE_PCT    = 21;
	localparam int HOLD_CYCLES = 80;
	localparam int STILL_LIMIT = 2000;
	localparam int PRINT_LIMIT = 40;

	typedef struct {
		logic [ACT_W-1:0] act;
		logic [TAG_W-1:0] tag;
		logic [ID_W-1:0]  id;
	} req_word_t;

	typedef struct {
		status_t          sts;
		logic [TAG_W-1:0] tag;
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] free_n;
		logic [CNT_W-1:0] wait_n;
		logic             fin;
	} rsp_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_W-1:0]    paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 req_valid;
	logic                 req_stall;
	logic [ACT_W-1:0]     action;
	logic [TAG_W-1:0]     requester_tag;
	logic [ID_W-1:0]      context_id;
	logic                 rsp_valid;
	logic                 rsp_stall;
	logic [STS_W-1:0]     status;
	logic [TAG_W-1:0]     requester_tag_res;
	logic [ID_W-1:0]      context_id_res;
	logic [CNT_W-1:0]     free_count;
	logic [CNT_W-1:0]     waiter_count;
	logic                 last;

	resource_pool_with_fifo_waiters_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.req_valid         (req_valid),
		.req_stall         (req_stall),
		.action            (action),
		.requester_tag     (requester_tag),
		.context_id        (context_id),
		.rsp_valid         (rsp_valid),
		.rsp_stall         (rsp_stall),
		.status            (status),
		.requester_tag_res (requester_tag_res),
		.context_id_res    (context_id_res),
		.free_count        (free_count),
		.waiter_count      (waiter_count),
		.last              (last)
	);

	// Shadow copy of the pool: register, free stack, waiter ring and closed flag.
	logic [CNT_W-1:0] count_shadow;
	logic [ID_W-1:0]  free_ids [SLOTS];
	int               free_top;
	logic [TAG_W-1:0] waiter_tags [QUEUE_DEPTH];
	logic [3:0]       waiter_rd;
	logic [3:0]       waiter_wr;
	int               waiters;
	logic             pool_shut;

	req_word_t pending_reqs [$];    // words waiting to be offered on the request side
	rsp_word_t expected_words [$];  // predicted response words, oldest first

	int reqs_sent;
	int reqs_taken;
	int errors;
	int still_cycles;
	int hold_left;
	bit hold_armed;
	bit hold_used;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Refill the free stack with ids 0 upwards; an oversized count saturates.
	function automatic void restock_ids();
		int n;
		n = (count_shadow > SLOTS) ? SLOTS : int'(count_shadow);
		for (int i = 0; i < n; i++)
			free_ids[i] = ID_W'(i);
		free_top = n;
	endfunction

	function automatic logic [TAG_W-1:0] pop_waiter();
		logic [TAG_W-1:0] t;
		t = waiter_tags[waiter_rd];
		waiter_rd = waiter_rd + 4'd1;
		waiters--;
		return t;
	endfunction

	// Work out the response words of one accepted request and queue them.
	function automatic void apply_request(req_word_t r);
		rsp_word_t step [$];
		rsp_word_t w;
		w.tag    = '0;
		w.id     = '0;
		w.free_n = '0;
		w.wait_n = '0;
		w.fin    = 1'b0;
		case (r.act)
			ACT_ACQUIRE: begin
				w.tag = r.tag;
				if (pool_shut) begin
					w.sts = STS_REFUSED_CLOSED;
				end else if (free_top > 0) begin
					free_top--;
					w.sts = STS_GRANTED;
					w.id  = free_ids[free_top];
				end else if (waiters < QUEUE_DEPTH) begin
					waiter_tags[waiter_wr] = r.tag;
					waiter_wr = waiter_wr + 4'd1;
					waiters++;
					w.sts = STS_QUEUED;
				end else begin
					w.sts = STS_REFUSED_FULL;
				end
				step = {step, w};
			end
			ACT_RELEASE: begin
				w.id = r.id;
				if (waiters > 0) begin
					w.sts = STS_HANDED;
					w.tag = pop_waiter();
				end else if (free_top < SLOTS) begin
					// no check for an id that is already free: push it again
					free_ids[free_top] = r.id;
					free_top++;
					w.sts = STS_RETURNED;
				end else begin
					// stack full: drop the id
					w.sts = STS_OVERFLOW;
				end
				step = {step, w};
			end
			ACT_CLOSE: begin
				if (pool_shut) begin
					w.sts = STS_ALREADY_CLOSED;
				end else begin
					pool_shut = 1'b1;
					// cancel waiters oldest first, then acknowledge
					while (waiters > 0) begin
						w.sts = STS_CANCELLED;
						w.tag = pop_waiter();
						step = {step, w};
					end
					waiter_rd = '0;
					waiter_wr = '0;
					w.tag = '0;
					w.sts = STS_CLOSE_DONE;
				end
				step = {step, w};
			end
			default: ;
		endcase
		// counts are taken after the whole request; last marks the final word
		foreach (step[k]) begin
			step[k].free_n = CNT_W'(free_top);
			step[k].wait_n = CNT_W'(waiters);
			step[k].fin    = (k == step.size() - 1);
			expected_words = {expected_words, step[k]};
		end
	endfunction

	function automatic void check_field(string what, int want, int got);
		if (want != got) begin
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	function automatic bit sender_idles();
		return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	// Request driver: take note of accepted words, then offer the next one.
	always @(posedge clk) begin : req_driver
		req_word_t nxt;
		req_word_t cur;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				cur.act = action;
				cur.tag = requester_tag;
				cur.id  = context_id;
				apply_request(cur);
				reqs_taken++;
			end
			// a stalled word must stay put; otherwise advance or idle
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() > 0 && !sender_idles()) begin
					nxt = pending_reqs[0];
					pending_reqs.delete(0);
					req_valid     <= 1'b1;
					action        <= nxt.act;
					requester_tag <= nxt.tag;
					context_id    <= nxt.id;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: check each accepted word, then choose next cycle's stall.
	always @(posedge clk) begin : rsp_monitor
		rsp_word_t w;
		bit stall_next;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= PRINT_LIMIT)
						$display("%0t: unexpected word, expected none, got status %0d tag %0d",
							$time, status, requester_tag_res);
				end else begin
					w = expected_words[0];
					expected_words.delete(0);
					check_field("status", w.sts, status);
					check_field("requester_tag_res", w.tag, requester_tag_res);
					check_field("context_id_res", w.id, context_id_res);
					check_field("free_count", w.free_n, free_count);
					check_field("waiter_count", w.wait_n, waiter_count);
					check_field("last", w.fin, last);
				end
			end
			// one long hold-off, counted here, so the block backs up into its input
			if (hold_armed && !hold_used) begin
				hold_left = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else begin
				stall_next = !quiet && ($urandom_range(0, 99) < IDLE_PCT);
			end
			rsp_stall <= stall_next;
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				still_cycles <= 0;
			end else if (still_cycles >= STILL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, still_cycles);
				$display("TB_ERROR");
				$finish;
			end else begin
				still_cycles <= still_cycles + 1;
			end
		end
	end

	task automatic offer(logic [ACT_W-1:0] act, logic [TAG_W-1:0] tag, logic [ID_W-1:0] id);
		req_word_t r;
		r.act = act;
		r.tag = tag;
		r.id  = id;
		pending_reqs = {pending_reqs, r};
		reqs_sent++;
	endtask

	// Random request with an acquire share of acq_pct percent; a few dropped codes.
	task automatic offer_random(int acq_pct);
		int r;
		logic [ACT_W-1:0] act;
		r = $urandom_range(0, 99);
		if (r < acq_pct)
			act = ACT_ACQUIRE;
		else if (r < 97)
			act = ACT_RELEASE;
		else
			act = ACT_NOP;
		offer(act, TAG_W'($urandom), ID_W'($urandom));
	endtask

	// Wait until every word is taken and answered, then let a dropped code drain.
	task automatic settle();
		while (reqs_taken != reqs_sent || expected_words.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Register write: setup cycle, then access cycle; the write lands at the end of the access cycle.
	task automatic pool_write(logic [CNT_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= POOL_COUNT_ADDR;
		pwdata  <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		count_shadow = value;
		restock_ids();
		@(negedge clk);
	endtask

	initial begin : stimulus
		int acq_pct;
		logic [CNT_W-1:0] size_pick;
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		req_valid     <= 1'b0;
		action        <= '0;
		requester_tag <= '0;
		context_id    <= '0;
		rsp_stall     <= 1'b0;
		reqs_sent     = 0;
		reqs_taken    = 0;
		errors        = 0;
		still_cycles  = 0;
		hold_left     = 0;
		hold_armed    = 1'b0;
		hold_used     = 1'b0;
		quiet         = 1'b0;
		count_shadow  = POOL_COUNT_RST;
		restock_ids();
		waiter_rd     = '0;
		waiter_wr     = '0;
		waiters       = 0;
		pool_shut     = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset pool: release into a full stack, extreme tags, a duplicate release,
		// a dropped code.
		offer(ACT_RELEASE, 8'h00, 4'hF);
		offer(ACT_ACQUIRE, 8'hFF, 4'h0);
		offer(ACT_ACQUIRE, 8'h00, 4'hF);
		offer(ACT_RELEASE, 8'h5A, 4'h0);
		offer(ACT_RELEASE, 8'hA5, 4'h0);
		offer(ACT_NOP, 8'hC3, 4'h9);
		offer(ACT_ACQUIRE, 8'h3C, 4'h6);
		settle();

		// Empty pool: acquirers queue, releases hand over oldest first.
		pool_write(5'd0);
		offer(ACT_ACQUIRE, 8'h01, 4'h0);
		offer(ACT_ACQUIRE, 8'h80, 4'h0);
		offer(ACT_ACQUIRE, 8'h7F, 4'h0);
		offer(ACT_RELEASE, 8'h00, 4'h9);
		offer(ACT_RELEASE, 8'h00, 4'h0);
		offer(ACT_RELEASE, 8'h00, 4'h6);
		offer(ACT_RELEASE, 8'h00, 4'h5);
		offer(ACT_ACQUIRE, 8'h42, 4'h0);
		offer(ACT_NOP, 8'h3C, 4'h6);
		settle();

		// Oversized count saturates to a full stack.
		pool_write(5'd31);
		offer(ACT_RELEASE, 8'hFF, 4'h3);
		settle();

		// Random episodes, each under a fresh pool size and acquire share.
		for (int ep = 0; ep < 5; ep++) begin
			case (ep)
				0: begin size_pick = 5'd2;  acq_pct = 60; end
				1: begin size_pick = 5'd0;  acq_pct = 75; end
				2: begin size_pick = 5'd17; acq_pct = 45; end
				3: begin size_pick = CNT_W'($urandom_range(0, 31)); acq_pct = 55; end
				default: begin size_pick = 5'd16; acq_pct = 30; end
			endcase
			pool_write(size_pick);
			quiet = (ep == 2);
			for (int i = 0; i < 16; i++)
				offer_random(acq_pct);
			// starve the response side while the sender keeps going
			if (ep == 1)
				hold_armed = 1'b1;
			settle();
		end
		quiet = 1'b0;

		// Fill the waiter queue past its depth, then close with every waiter cancelled.
		pool_write(5'd0);
		repeat (QUEUE_DEPTH + 1)
			offer(ACT_ACQUIRE, TAG_W'($urandom), ID_W'($urandom));
		offer(ACT_CLOSE, 8'h00, 4'h0);
		offer(ACT_CLOSE, 8'hFF, 4'hF);
		offer(ACT_ACQUIRE, 8'h99, 4'h0);
		offer(ACT_RELEASE, 8'h00, 4'hC);
		// noise on a closed pool, closes included
		repeat (15)
			offer(ACT_W'($urandom_range(0, 3)), TAG_W'($urandom), ID_W'($urandom));
		settle();

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
